// ===== hdl/mfti_pkg.sv =====
`timescale 1ns / 1ps

package mfti_pkg;

    localparam int NUM_REGS   = 24;
    localparam int NUM_TIMERS = 4;

    // Action codes carried in the input transaction
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_ACK   = 2'd3;

    // Register map
    localparam logic [4:0] R_IEA   = 5'd3;
    localparam logic [4:0] R_IPA   = 5'd5;
    localparam logic [4:0] R_IPB   = 5'd6;
    localparam logic [4:0] R_ISA   = 5'd7;
    localparam logic [4:0] R_ISB   = 5'd8;
    localparam logic [4:0] R_IMA   = 5'd9;
    localparam logic [4:0] R_VCR   = 5'd11;
    localparam logic [4:0] R_TACR  = 5'd12;
    localparam logic [4:0] R_TBCR  = 5'd13;
    localparam logic [4:0] R_TCDCR = 5'd14;
    localparam logic [4:0] R_TADR  = 5'd15;
    localparam logic [4:0] R_TBDR  = 5'd16;
    localparam logic [4:0] R_TCDR  = 5'd17;
    localparam logic [4:0] R_TDDR  = 5'd18;

    localparam logic [7:0] VCR_RESET    = 8'h40;
    localparam logic [7:0] VCR_WR_MASK  = 8'hF8;
    localparam logic [7:0] VCR_VEC_MASK = 8'hF0;
    localparam int         VCR_S_BIT    = 3;
    localparam logic [8:0] COUNT_FULL   = 9'd256;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] reg_select;
        logic [7:0] write_data;
    } mfti_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pending;
        logic [7:0] vector;
        logic       vector_valid;
    } mfti_out_t;

    function automatic logic [7:0] prescale(input logic [2:0] mode);
        logic [7:0] p;
        case (mode)
            3'd1:    p = 8'd4;
            3'd2:    p = 8'd10;
            3'd3:    p = 8'd16;
            3'd4:    p = 8'd50;
            3'd5:    p = 8'd64;
            3'd6:    p = 8'd100;
            3'd7:    p = 8'd200;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

    // Low vector nibble per timer, A..D
    function automatic logic [7:0] timer_vec(input logic [1:0] t);
        logic [7:0] v;
        case (t)
            2'd0:    v = 8'd13;
            2'd1:    v = 8'd8;
            2'd2:    v = 8'd5;
            default: v = 8'd4;
        endcase
        return v;
    endfunction

    // Bit of the timer within its interrupt bank
    function automatic logic [7:0] timer_mask(input logic [1:0] t);
        logic [7:0] m;
        case (t)
            2'd0:    m = 8'h20;
            2'd1:    m = 8'h01;
            2'd2:    m = 8'h20;
            default: m = 8'h10;
        endcase
        return m;
    endfunction

    // Offset of the timer's bank: A and B in bank A, C and D in bank B
    function automatic logic [4:0] timer_bank(input logic [1:0] t);
        return (t[1]) ? 5'd1 : 5'd0;
    endfunction

    // Data byte of zero loads a full count
    function automatic logic [8:0] expand(input logic [7:0] b);
        return (b != 8'd0) ? {1'b0, b} : COUNT_FULL;
    endfunction

endpackage

// ===== hdl/multi_function_timer_interrupt_unit.sv =====
`timescale 1ns / 1ps

// Channel  | Ports                      | Direction | Payload
// ---------+----------------------------+-----------+-------------------------------
// input    | s_valid, s_ready, s_data   | in        | action, reg_select, write_data
// result   | m_valid, m_ready, m_data   | out       | read_data, irq_pending, vector,
//          |                            |           | vector_valid
//
// One transaction per cycle while s_ready is high: every action (read, write,
// tick, acknowledge) is resolved in the cycle it is accepted, by the logic
// between the register file, the four timer counters and the result buffer; its
// result is registered. Reset (aresetn low, synchronous) restores the register
// file, the counts (256) and the prescaler phases, and empties the result
// buffer. A two-entry result buffer (output register plus skid register) keeps
// s_ready high while one result waits for m_ready; input stalls only when both hold.

module multi_function_timer_interrupt_unit
    import mfti_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  mfti_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output mfti_out_t m_data
);

    // Architectural state
    logic [7:0] regs_reg  [NUM_REGS];
    logic [7:0] regs_next [NUM_REGS];
    logic [8:0] cnt_reg   [NUM_TIMERS];
    logic [8:0] cnt_next  [NUM_TIMERS];
    logic [7:0] ph_reg    [NUM_TIMERS];
    logic [7:0] ph_next   [NUM_TIMERS];

    // Result buffer: head drives the port, skid catches a result during a stall
    mfti_out_t head_reg, head_next;
    mfti_out_t skid_reg, skid_next;
    logic      head_valid_reg, head_valid_next;
    logic      skid_valid_reg, skid_valid_next;

    logic      push;
    logic      pop;
    mfti_out_t result;

    logic [2:0] cur_mode [NUM_TIMERS];
    logic [2:0] new_mode [NUM_TIMERS];
    logic [7:0] ph_inc   [NUM_TIMERS];
    logic [4:0] sel;
    logic [7:0] wdata;
    logic [4:0] toff;
    logic [1:0] tsel;
    logic       s_flag;
    logic       found;
    logic [4:0] bank;
    logic [7:0] mask;

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign pop     = head_valid_reg && m_ready;
    assign m_valid = head_valid_reg;
    assign m_data  = head_reg;

    assign sel    = s_data.reg_select;
    assign wdata  = s_data.write_data;
    assign toff   = sel - R_TADR;
    assign tsel   = toff[1:0];
    assign s_flag = regs_reg[R_VCR][VCR_S_BIT];

    // Decode the running mode of each timer from the control registers
    assign cur_mode[0] = regs_reg[R_TACR][2:0];
    assign cur_mode[1] = regs_reg[R_TBCR][2:0];
    assign cur_mode[2] = regs_reg[R_TCDCR][6:4];
    assign cur_mode[3] = regs_reg[R_TCDCR][2:0];

    // Modes a control write would install
    assign new_mode[0] = wdata[2:0];
    assign new_mode[1] = wdata[2:0];
    assign new_mode[2] = wdata[6:4];
    assign new_mode[3] = wdata[2:0];

    always_comb begin
        for (int t = 0; t < NUM_TIMERS; t++) begin
            ph_inc[t] = ph_reg[t] + 8'd1;
        end
    end

    // Apply the accepted transaction to the state and form its result
    always_comb begin
        regs_next = regs_reg;
        cnt_next  = cnt_reg;
        ph_next   = ph_reg;
        result    = '0;
        found     = 1'b0;
        bank      = 5'd0;
        mask      = 8'd0;

        case (s_data.action)
            ACT_READ: begin
                // Timer data registers read back the live count
                if (sel >= R_TADR && sel <= R_TDDR) begin
                    result.read_data = cnt_reg[tsel][7:0];
                end else if (sel < 5'(NUM_REGS)) begin
                    result.read_data = regs_reg[sel];
                end
            end
            ACT_WRITE: begin
                case (sel)
                    R_IPA, R_IPB: begin
                        regs_next[sel] = regs_reg[sel] & wdata;
                    end
                    R_ISA, R_ISB: begin
                        // In-service bits clear by write only in software EOI mode
                        if (s_flag) begin
                            regs_next[sel] = regs_reg[sel] & wdata;
                        end
                    end
                    R_VCR: begin
                        regs_next[R_VCR] = wdata & VCR_WR_MASK;
                        if (!wdata[VCR_S_BIT]) begin
                            regs_next[R_ISA] = 8'd0;
                            regs_next[R_ISB] = 8'd0;
                        end
                    end
                    R_TACR: begin
                        if (new_mode[0] == 3'd0 || new_mode[0] != cur_mode[0]) begin
                            ph_next[0] = 8'd0;
                        end
                        regs_next[R_TACR] = wdata;
                    end
                    R_TBCR: begin
                        if (new_mode[1] == 3'd0 || new_mode[1] != cur_mode[1]) begin
                            ph_next[1] = 8'd0;
                        end
                        regs_next[R_TBCR] = wdata;
                    end
                    R_TCDCR: begin
                        if (new_mode[2] == 3'd0 || new_mode[2] != cur_mode[2]) begin
                            ph_next[2] = 8'd0;
                        end
                        if (new_mode[3] == 3'd0 || new_mode[3] != cur_mode[3]) begin
                            ph_next[3] = 8'd0;
                        end
                        regs_next[R_TCDCR] = wdata;
                    end
                    R_TADR, R_TBDR, R_TCDR, R_TDDR: begin
                        // A stopped timer loads at once; a running one at expiry
                        regs_next[sel] = wdata;
                        if (cur_mode[tsel] == 3'd0) begin
                            cnt_next[tsel] = expand(wdata);
                        end
                    end
                    default: begin
                        if (sel < 5'(NUM_REGS)) begin
                            regs_next[sel] = wdata;
                        end
                    end
                endcase
            end
            ACT_TICK: begin
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    bank = timer_bank(2'(t));
                    mask = timer_mask(2'(t));
                    if (cur_mode[t] != 3'd0) begin
                        if (ph_inc[t] < prescale(cur_mode[t])) begin
                            ph_next[t] = ph_inc[t];
                        end else begin
                            ph_next[t] = 8'd0;
                            if (cnt_reg[t] > 9'd1) begin
                                cnt_next[t] = cnt_reg[t] - 9'd1;
                            end else begin
                                // Expiry: raise the request if enabled, reload from the data byte
                                if ((regs_reg[R_IEA + bank] & mask) != 8'd0) begin
                                    regs_next[R_IPA + bank] = regs_next[R_IPA + bank] | mask;
                                    if (((regs_reg[R_IMA + bank] & mask) != 8'd0) && s_flag) begin
                                        regs_next[R_ISA + bank] =
                                            regs_next[R_ISA + bank] | mask;
                                    end
                                end
                                cnt_next[t] = expand(regs_reg[R_TADR + 5'(t)]);
                            end
                        end
                    end
                end
            end
            ACT_ACK: begin
                result.vector = regs_reg[R_VCR] & VCR_VEC_MASK;
                // Priority A, B, C, D: take the first requester
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    bank = timer_bank(2'(t));
                    mask = timer_mask(2'(t));
                    if (!found && ((regs_reg[R_IEA + bank] & regs_reg[R_IMA + bank]
                                    & regs_reg[R_IPA + bank] & mask) != 8'd0)) begin
                        found = 1'b1;
                        result.vector = result.vector | timer_vec(2'(t));
                        result.vector_valid = 1'b1;
                        if (!s_flag) begin
                            // Automatic EOI: drop pending and in-service
                            regs_next[R_IPA + bank] = regs_reg[R_IPA + bank] & ~mask;
                            regs_next[R_ISA + bank] = regs_reg[R_ISA + bank] & ~mask;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // Request line reflects the state after this transaction
        for (int t = 0; t < NUM_TIMERS; t++) begin
            if ((regs_next[R_IEA + timer_bank(2'(t))] & regs_next[R_IMA + timer_bank(2'(t))]
                 & regs_next[R_IPA + timer_bank(2'(t))] & timer_mask(2'(t))) != 8'd0) begin
                result.irq_pending = 1'b1;
            end
        end
    end

    // Result buffer steering
    always_comb begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                head_valid_next = 1'b0;
            end
        end
        if (push) begin
            if (!head_valid_next) begin
                head_next       = result;
                head_valid_next = 1'b1;
            end else begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    // State registers: architectural state advances only on an accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= (i == int'(R_VCR)) ? VCR_RESET : 8'd0;
            end
            for (int t = 0; t < NUM_TIMERS; t++) begin
                cnt_reg[t] <= COUNT_FULL;
                ph_reg[t]  <= 8'd0;
            end
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                regs_reg <= regs_next;
                cnt_reg  <= cnt_next;
                ph_reg   <= ph_next;
            end
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold result payloads; no reset needed
    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule
